// ----- src/module_slot_fuel_table_assert.svh -----
// Assertion macros for the module slot fuel table.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MODULE_SLOT_FUEL_TABLE_ASSERT_SVH
`define MODULE_SLOT_FUEL_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define MSFT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("msft: same-cycle check failed");
// Next-cycle implication, checked outside reset
`define MSFT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("msft: next-cycle check failed");
`else
`define MSFT_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define MSFT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- src/msft_pkg.sv -----
// Shared types and constants for the module slot fuel table.
// No dependencies.
package msft_pkg;

    // Request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_INST   = 2'd1,
        REQ_CHARGE = 2'd2,
        REQ_STATUS = 2'd3
    } req_t;

    // Slot lifecycle codes as reported in slot_status
    typedef enum logic [2:0] {
        LC_UNLOADED     = 3'd0,
        LC_LOADED       = 3'd1,
        LC_INSTANTIATED = 3'd2,
        LC_RUNNING      = 3'd3,
        LC_TRAPPED      = 3'd4
    } lifecycle_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_PAGE_LIMIT  = 1'b0,
        CFG_FUEL_BUDGET = 1'b1
    } cfg_idx_t;

    localparam int unsigned PAGE_W = 17;
    localparam int unsigned FUEL_W = 32;
    localparam int unsigned IDX_W  = 4;

    localparam logic [PAGE_W-1:0] DEFAULT_PAGES = 17'd256;
    localparam logic [FUEL_W-1:0] DEFAULT_FUEL  = 32'd1000000;

endpackage

// ----- src/module_slot_fuel_table.sv -----
// Module slot fuel table: slot lifecycle, fuel credit and import mask per slot.
// Depends on msft_pkg and module_slot_fuel_table_assert.svh.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata, s_tuser (request kind)
//  m_      | out       | m_tvalid/m_tready  | m_tdata (result word)
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// Each word is handled as a slot read, then the update, write-back and output
// load; s_tready stays low until the update completes, so reads never see stale slots.
// The update stalls while the output register holds a word not yet taken.
// Reset clears the fill count and loads the register defaults; slot entries are
// not cleared (only slots below the fill count are ever used), so no clearing pass.
`include "module_slot_fuel_table_assert.svh"

module module_slot_fuel_table #(
    parameter int unsigned SLOT_COUNT  = 16,
    parameter int unsigned IMPORT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata from bit 0: slot_index[3:0], page_request[16:0],
    // needed_imports[15:0], granted_mask[15:0], fuel_charge[31:0], zero pad
    input  logic [87:0] s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: fail, new_slot[3:0], slot_status[2:0],
    // slots_used[4:0], fuel_left[31:0], zero pad
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import msft_pkg::*;

    localparam int unsigned ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Slot memories
    lifecycle_t              life_mem [SLOT_COUNT];
    logic [FUEL_W-1:0]       fuel_mem [SLOT_COUNT];
    logic [IMPORT_BITS-1:0]  imp_mem  [SLOT_COUNT];

    // Control and configuration
    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        used_count_reg, used_count_next;
    logic [PAGE_W-1:0]       page_limit_reg;
    logic [FUEL_W-1:0]       fuel_budget_reg;
    logic                    m_tvalid_reg;

    // Request held for the update cycle
    req_t                    req_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [PAGE_W-1:0]       pages_reg;
    logic [IMPORT_BITS-1:0]  needed_reg;
    logic [IMPORT_BITS-1:0]  granted_reg;
    logic [FUEL_W-1:0]       charge_reg;

    // Read data
    lifecycle_t              rd_life_reg;
    logic [FUEL_W-1:0]       rd_fuel_reg;
    logic [IMPORT_BITS-1:0]  rd_imp_reg;

    // Output word
    logic [47:0]             m_tdata_reg, m_tdata_next;

    // Update cycle signals
    logic                    accept;
    logic                    out_free;
    logic                    finish;
    logic [PAGE_W-1:0]       limit;
    logic [FUEL_W-1:0]       budget;
    logic                    idx_ok;
    logic                    load_ok;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    lifecycle_t              wr_life;
    logic [FUEL_W-1:0]       wr_fuel;
    logic [IMPORT_BITS-1:0]  wr_imp;
    logic                    res_fail;
    logic [IDX_W-1:0]        res_slot;
    lifecycle_t              res_status;
    logic [FUEL_W-1:0]       res_fuel;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = busy_reg && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg  <= DEFAULT_PAGES;
            fuel_budget_reg <= DEFAULT_FUEL;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PAGE_LIMIT:  page_limit_reg  <= cfg_wdata[PAGE_W-1:0];
                CFG_FUEL_BUDGET: fuel_budget_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the request and read the addressed slot
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg     <= req_t'(s_tuser);
            idx_reg     <= s_tdata[3:0];
            pages_reg   <= s_tdata[20:4];
            needed_reg  <= IMPORT_BITS'(s_tdata[36:21]);
            granted_reg <= IMPORT_BITS'(s_tdata[52:37]);
            charge_reg  <= s_tdata[84:53];
            rd_life_reg <= life_mem[ADDR_W'(s_tdata[3:0])];
            rd_fuel_reg <= fuel_mem[ADDR_W'(s_tdata[3:0])];
            rd_imp_reg  <= imp_mem[ADDR_W'(s_tdata[3:0])];
        end
    end

    // Write back the updated slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            life_mem[wr_addr] <= wr_life;
            fuel_mem[wr_addr] <= wr_fuel;
            imp_mem[wr_addr]  <= wr_imp;
        end
    end

    // Update the slot and form the result
    always_comb begin
        limit   = (page_limit_reg == '0) ? DEFAULT_PAGES : page_limit_reg;
        budget  = (fuel_budget_reg == '0) ? DEFAULT_FUEL : fuel_budget_reg;
        idx_ok  = CMP_W'(idx_reg) < CMP_W'(used_count_reg);
        load_ok = (used_count_reg < CNT_W'(SLOT_COUNT)) && (pages_reg <= limit);

        wr_en      = 1'b0;
        wr_addr    = ADDR_W'(idx_reg);
        wr_life    = rd_life_reg;
        wr_fuel    = rd_fuel_reg;
        wr_imp     = rd_imp_reg;
        res_fail   = 1'b1;
        res_slot   = '0;
        res_status = LC_UNLOADED;
        res_fuel   = '0;
        used_count_next = used_count_reg;

        case (req_reg)
            REQ_LOAD: begin
                if (load_ok) begin
                    wr_en      = finish;
                    wr_addr    = ADDR_W'(used_count_reg);
                    wr_life    = LC_LOADED;
                    wr_fuel    = budget;
                    wr_imp     = needed_reg;
                    res_fail   = 1'b0;
                    res_slot   = IDX_W'(used_count_reg);
                    used_count_next = used_count_reg + CNT_W'(1);
                end
            end
            REQ_INST: begin
                if (idx_ok && rd_life_reg == LC_LOADED &&
                    (rd_imp_reg & ~granted_reg) == '0) begin
                    wr_en    = finish;
                    wr_life  = LC_INSTANTIATED;
                    res_fail = 1'b0;
                end
            end
            REQ_CHARGE: begin
                if (idx_ok) begin
                    wr_en = finish;
                    if (charge_reg > rd_fuel_reg) begin
                        wr_fuel = '0;
                        wr_life = LC_TRAPPED;
                    end else begin
                        wr_fuel  = rd_fuel_reg - charge_reg;
                        res_fail = 1'b0;
                    end
                end
            end
            REQ_STATUS: begin
                if (idx_ok) begin
                    res_fail = (rd_life_reg == LC_TRAPPED);
                end
            end
            default: ;
        endcase

        // Report the slot after the request when one is involved
        if ((req_reg == REQ_LOAD && load_ok) || (req_reg != REQ_LOAD && idx_ok)) begin
            res_status = wr_life;
            res_fuel   = wr_fuel;
        end

        if (!finish) begin
            used_count_next = used_count_reg;
        end

        m_tdata_next = {3'b000, res_fuel, 5'(used_count_next), 3'(res_status),
                        res_slot, res_fail};

        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (finish) begin
            busy_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            used_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            used_count_reg <= used_count_next;
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Checks
    `MSFT_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, used_count_reg <= CNT_W'(SLOT_COUNT))
    `MSFT_ASSERT_NEXT(a_finish_shows, aclk, aresetn, finish, m_tvalid_reg && !busy_reg)
    `MSFT_ASSERT_NEXT(a_count_only_load, aclk, aresetn, !(finish && req_reg == REQ_LOAD && load_ok), $stable(used_count_reg))

endmodule

// ----- sim/slot_table_checker.sv -----
// Checker for the module slot fuel table: watches the request, result and register ports.
// Keeps its own copy of the slot table, predicts each result word and compares it.
// Depends on msft_pkg.
module slot_table_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata from bit 0: slot_index[3:0], page_request[16:0],
    // needed_imports[15:0], granted_mask[15:0], fuel_charge[31:0], zero pad
    input  logic [87:0] s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // tdata from bit 0: fail, new_slot[3:0], slot_status[2:0],
    // slots_used[4:0], fuel_left[31:0], zero pad
    input  logic [47:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          mismatch_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import msft_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic        fail;
        logic [3:0]  new_slot;
        logic [2:0]  slot_status;
        logic [4:0]  slots_used;
        logic [31:0] fuel_left;
    } outcome_t;

    // Shadow registers and slot table
    logic [PAGE_W-1:0] page_limit_q;
    logic [FUEL_W-1:0] fuel_budget_q;
    logic [4:0]        loaded_slots;
    lifecycle_t        phase_of   [SLOTS];
    logic [31:0]       credit_of  [SLOTS];
    logic [15:0]       imports_of [SLOTS];

    outcome_t awaited_outcomes[$];

    // Apply one request to the shadow table and work out its result word
    task automatic serve_request(input req_t kind, input logic [3:0] idx,
                                 input logic [16:0] pages, input logic [15:0] needed,
                                 input logic [15:0] granted, input logic [31:0] charge,
                                 output outcome_t res);
        logic [PAGE_W-1:0] lim;
        logic [FUEL_W-1:0] grant_fuel;
        lim        = (page_limit_q == '0) ? DEFAULT_PAGES : page_limit_q;
        grant_fuel = (fuel_budget_q == '0) ? DEFAULT_FUEL : fuel_budget_q;
        res        = '0;
        res.fail   = 1'b1;
        if (kind == REQ_LOAD) begin
            // take the next free slot when there is one and the pages fit
            if (loaded_slots < SLOTS && pages <= lim) begin
                phase_of[loaded_slots[3:0]]   = LC_LOADED;
                credit_of[loaded_slots[3:0]]  = grant_fuel;
                imports_of[loaded_slots[3:0]] = needed;
                res.fail        = 1'b0;
                res.new_slot    = loaded_slots[3:0];
                res.slot_status = LC_LOADED;
                res.fuel_left   = grant_fuel;
                loaded_slots    = loaded_slots + 5'd1;
            end
        end else if ({1'b0, idx} < loaded_slots) begin
            case (kind)
                REQ_INST: begin
                    if (phase_of[idx] == LC_LOADED && (imports_of[idx] & ~granted) == '0) begin
                        phase_of[idx] = LC_INSTANTIATED;
                        res.fail      = 1'b0;
                    end
                end
                REQ_CHARGE: begin
                    // overdraw drains the credit and traps the slot
                    if (charge > credit_of[idx]) begin
                        credit_of[idx] = '0;
                        phase_of[idx]  = LC_TRAPPED;
                    end else begin
                        credit_of[idx] = credit_of[idx] - charge;
                        res.fail       = 1'b0;
                    end
                end
                default: begin
                    res.fail = (phase_of[idx] == LC_TRAPPED);
                end
            endcase
            res.slot_status = phase_of[idx];
            res.fuel_left   = credit_of[idx];
        end
        res.slots_used = loaded_slots;
    endtask

    // Report one field; returns 1 on a mismatch
    function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 1'b0;
        $display("%0t slot_table_checker: %s expected %0h got %0h", $time, name, want, got);
        return 1'b1;
    endfunction

    // Track registers, requests and results at each rising edge
    always @(posedge aclk) begin : watch
        outcome_t want;
        outcome_t got;
        bit       bad;
        if (!aresetn) begin
            page_limit_q  = DEFAULT_PAGES;
            fuel_budget_q = DEFAULT_FUEL;
            loaded_slots  = '0;
            awaited_outcomes.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_idx_t'(cfg_index) == CFG_PAGE_LIMIT)
                    page_limit_q = cfg_wdata[PAGE_W-1:0];
                else
                    fuel_budget_q = cfg_wdata[FUEL_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                serve_request(req_t'(s_tuser), s_tdata[3:0], s_tdata[20:4], s_tdata[36:21],
                              s_tdata[52:37], s_tdata[84:53], want);
                awaited_outcomes.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.fail        = m_tdata[0];
                got.new_slot    = m_tdata[4:1];
                got.slot_status = m_tdata[7:5];
                got.slots_used  = m_tdata[12:8];
                got.fuel_left   = m_tdata[44:13];
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t slot_table_checker: unexpected word, expected none got %0h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("fail", 32'(want.fail), 32'(got.fail));
                    bad |= field_differs("new_slot", 32'(want.new_slot), 32'(got.new_slot));
                    bad |= field_differs("slot_status", 32'(want.slot_status),
                                         32'(got.slot_status));
                    bad |= field_differs("slots_used", 32'(want.slots_used),
                                         32'(got.slots_used));
                    bad |= field_differs("fuel_left", want.fuel_left, got.fuel_left);
                    if (bad)
                        mismatch_count++;
                end
            end
        end
        pending_count = awaited_outcomes.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the module slot fuel table testbench: clock, reset, requests and register writes.
// Depends on msft_pkg, module_slot_fuel_table and slot_table_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msft_pkg::*;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int PHASES = 5;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    int          mismatch_count;
    int          pending_count;

    bit          calm = 1'b0;
    int          ready_hold = 0;

    always #10 aclk = ~aclk;

    module_slot_fuel_table u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    slot_table_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Stall the result side in random bursts
    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one request word at a falling edge and hold it until taken
    task automatic issue(input req_t kind, input logic [3:0] idx, input logic [16:0] pages,
                         input logic [15:0] needed, input logic [15:0] granted,
                         input logic [31:0] charge);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b0, charge, granted, needed, pages, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid and wait for every pending result word
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    // Write both registers on back-to-back cycles while the block is idle
    task automatic write_settings(input logic [31:0] pages, input logic [31:0] fuel);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGE_LIMIT;
        cfg_wdata <= pages;
        @(negedge aclk);
        cfg_index <= CFG_FUEL_BUDGET;
        cfg_wdata <= fuel;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [31:0] phase_pages [PHASES];
        logic [31:0] phase_fuel  [PHASES];
        logic [16:0] lim;
        logic [15:0] needed;
        logic [15:0] granted;
        logic [31:0] charge;
        req_t        kind;
        int          load_pct;
        int          pick;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_LOAD;
        cfg_we    = 1'b0;
        cfg_index = CFG_PAGE_LIMIT;
        cfg_wdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table, size limits, import checks, fuel edges, traps
        issue(REQ_STATUS, 4'd0, 17'd0, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_INST, 4'd5, 17'd0, 16'h0000, 16'hFFFF, 32'd0);
        issue(REQ_CHARGE, 4'd15, 17'd0, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        issue(REQ_LOAD, 4'd0, 17'd257, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_LOAD, 4'd15, 17'd65536, 16'hFFFF, 16'h0000, 32'd0);
        issue(REQ_LOAD, 4'd0, 17'd256, 16'hFFFF, 16'h0000, 32'd0);
        issue(REQ_LOAD, 4'd7, 17'd0, 16'h0000, 16'hFFFF, 32'd0);
        issue(REQ_STATUS, 4'd1, 17'd0, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_INST, 4'd0, 17'd0, 16'h0000, 16'h7FFF, 32'd0);
        issue(REQ_INST, 4'd0, 17'd0, 16'h0000, 16'hFFFF, 32'd0);
        issue(REQ_INST, 4'd0, 17'd0, 16'h0000, 16'hFFFF, 32'd0);
        issue(REQ_INST, 4'd1, 17'd0, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_CHARGE, 4'd0, 17'd0, 16'h0000, 16'h0000, 32'd1000000);
        issue(REQ_CHARGE, 4'd0, 17'd0, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_CHARGE, 4'd0, 17'd0, 16'h0000, 16'h0000, 32'd1);
        issue(REQ_STATUS, 4'd0, 17'd0, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_CHARGE, 4'd0, 17'd0, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_INST, 4'd0, 17'd0, 16'h0000, 16'hFFFF, 32'd0);
        issue(REQ_CHARGE, 4'd1, 17'd0, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        issue(REQ_STATUS, 4'd2, 17'd0, 16'h0000, 16'h0000, 32'd0);
        issue(REQ_LOAD, 4'd15, 17'd1, 16'h8001, 16'h0000, 32'd0);

        // Register settings per phase: defaults by zero, extremes, then random
        phase_pages[0] = 32'd0;
        phase_fuel[0]  = 32'd0;
        phase_pages[1] = 32'd65536;
        phase_fuel[1]  = 32'hFFFF_FFFF;
        phase_pages[2] = 32'd1;
        phase_fuel[2]  = 32'd1;
        phase_pages[3] = $urandom_range(2, 65535);
        phase_fuel[3]  = $urandom;
        phase_pages[4] = $urandom_range(0, 65536);
        phase_fuel[4]  = $urandom_range(0, 5000);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_settings(phase_pages[p], phase_fuel[p]);
            lim = (phase_pages[p][16:0] == '0) ? DEFAULT_PAGES : phase_pages[p][16:0];
            // last phase runs without idling and loads more often to fill the table
            calm     = (p == PHASES - 1);
            load_pct = calm ? 12 : 3;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < load_pct)
                    kind = REQ_LOAD;
                else if (pick < load_pct + 25)
                    kind = REQ_INST;
                else if (pick < load_pct + 65)
                    kind = REQ_CHARGE;
                else
                    kind = REQ_STATUS;
                // sparse, empty or dense import needs
                case ($urandom_range(0, 2))
                    0: needed = '0;
                    1: needed = 16'($urandom & $urandom & $urandom);
                    default: needed = 16'($urandom);
                endcase
                case ($urandom_range(0, 2))
                    0: granted = 16'hFFFF;
                    1: granted = 16'($urandom | $urandom);
                    default: granted = 16'($urandom);
                endcase
                // mostly small charges, sometimes any value
                case ($urandom_range(0, 3))
                    0: charge = $urandom_range(0, 3);
                    1: charge = $urandom_range(0, 1000);
                    2: charge = $urandom_range(0, 300000);
                    default: charge = $urandom;
                endcase
                issue(kind, 4'($urandom_range(0, 15)),
                      $urandom_range(0, 1) ? 17'($urandom_range(0, lim))
                                           : 17'($urandom_range(0, 65536)),
                      needed, granted, charge);
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Stop a run that hangs
    initial begin : watchdog
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
